>>> src/rfl_pkg.sv
// Shared constants, payload types and control structs of the masked rank filter.
`default_nettype none
package rfl_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_HALF = 3;
  localparam int SLOTS    = 2 * MAX_HALF + 1;
  localparam int WIN_N    = SLOTS * SLOTS;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int POS_W    = $clog2(WIN_N);
  localparam int CNT_W    = $clog2(WIN_N + 1);
  localparam int ADDR_W   = $clog2(SLOTS * MAX_ROWS);

  // Field widths of the register file
  localparam int FR_W   = 11;
  localparam int FC_W   = 16;
  localparam int HALF_W = 2;
  localparam int ELEM_W = 49;
  localparam int RANK_W = 6;
  localparam int CFG_W  = 49;
  localparam int IDX_W  = 3;
  localparam int PIX_W  = 8;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_ROWS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_COLS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] REG_HALF_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ELEMENT     = 3'd4;
  localparam logic [IDX_W-1:0] REG_RANK        = 3'd5;
  localparam logic [IDX_W-1:0] REG_MASK_EN     = 3'd6;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             mask_bit;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_t;

  typedef struct packed {
    logic             mask;
    logic [PIX_W-1:0] pixel;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] rank;
  } sel_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] value;
  } sel_stat_t;

endpackage
`default_nettype wire

>>> src/rfl_store.sv
// Column store: one write port and one registered read port.
`default_nettype none
module rfl_store
  import rfl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output entry_t                 rdata
);

  entry_t mem [SLOTS*MAX_ROWS];

  // Write the new word, read the requested one
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/rfl_select.sv
// Bit-serial rank selection over the captured window, most significant bit first.
`default_nettype none
module rfl_select
  import rfl_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sel_ctrl_t                   ctrl,
  input  wire logic [WIN_N-1:0][PIX_W-1:0] pix,
  input  wire logic [WIN_N-1:0]            sel,
  output sel_stat_t                        stat
);

  logic                      busy;
  logic [WIN_N-1:0]          act;
  logic [CNT_W-1:0]          rank;
  logic [$clog2(PIX_W)-1:0]  bitn;
  logic [PIX_W-1:0]          value;
  logic                      done;
  logic [WIN_N-1:0]          zv;
  logic [CNT_W-1:0]          zcnt;
  logic [CNT_W-1:0]          scnt;

  // Count candidates with a zero in the current bit plane
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      zv[i] = act[i] & ~pix[i][bitn];
    end
    zcnt = CNT_W'($countones(zv));
    scnt = CNT_W'($countones(sel));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        act   <= sel;
        bitn  <= 3'(PIX_W - 1);
        value <= '0;
        if (scnt == '0) begin
          // empty element gives zero
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          rank <= (CNT_W'(ctrl.rank) >= scnt) ? scnt - 1'b1 : CNT_W'(ctrl.rank);
        end
      end else if (busy) begin
        // keep the half that holds the ranked value
        if (rank < zcnt) begin
          act         <= zv;
          value[bitn] <= 1'b0;
        end else begin
          act         <= act & ~zv;
          rank        <= rank - zcnt;
          value[bitn] <= 1'b1;
        end
        if (bitn == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bitn <= bitn - 1'b1;
        end
      end
    end
  end

  assign stat.done  = done;
  assign stat.value = value;

endmodule
`default_nettype wire

>>> src/masked_2d_rank_filter_core.sv
// Masked 2D rank filter: scan tracking, window fetch, selection and output word.
// Sequence for an interior pixel once taken: a center read, one column-store read per window
// position, a drain and a start state, bit-serial selection (skipped when the mask passes the
// center pixel) and a load of the output register, which waits while that register is full.
// Throughput: one pixel per cycle outside the interior; inside, no new pixel is taken until the
// word of the last one is loaded, as the single store read port and the bit-plane loop are busy.
// Reset: synchronous, registers to defaults, scan position to zero; store contents undefined.
`default_nettype none
module masked_2d_rank_filter_core
  import rfl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CENTER = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_SEL    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;
  localparam logic [2:0] ST_START  = 3'd6;

  // Registers
  logic [FR_W-1:0]   frame_rows;
  logic [FC_W-1:0]   frame_cols;
  logic [HALF_W-1:0] half_height;
  logic [HALF_W-1:0] half_width;
  logic [ELEM_W-1:0] element_bits;
  logic [RANK_W-1:0] rank_index;
  logic              mask_enable;

  logic [2:0]        state;
  logic [ROW_W-1:0]  row_pos;
  logic [FC_W-1:0]   col_pos;
  logic [SLOT_W-1:0] wslot;
  logic              cur_last;
  logic [ROW_W-1:0]  base_row;
  logic [ROW_W-1:0]  ctr_row;
  logic [SLOT_W-1:0] ctr_slot;
  logic [SLOT_W-1:0] rslot;
  logic [SLOT_W-1:0] ccnt;
  logic [2:0]        kcnt;
  logic [POS_W-1:0]  pos;
  logic              rd_valid;
  logic              rd_center;
  logic [POS_W-1:0]  rd_pos;
  entry_t            center;
  logic [WIN_N-1:0][PIX_W-1:0] win_pix;
  logic [WIN_N-1:0]  win_sel;
  logic [PIX_W-1:0]  result;

  // Effective sizes
  logic [FR_W-1:0]   rows_eff;
  logic [FC_W-1:0]   cols_eff;
  logic [HALF_W-1:0] hh;
  logic [HALF_W-1:0] hw;
  logic [2:0]        wh;
  logic [2:0]        nslot;
  logic              win_ok;
  logic              row_end;
  logic              col_end;
  logic [SLOT_W:0]   cslot_sum;
  logic [SLOT_W-1:0] wslot_inc;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ROW_W-1:0]  rd_row;
  logic [SLOT_W-1:0] rd_slot;
  entry_t            rdata;
  sel_ctrl_t         sctrl;
  sel_stat_t         sstat;
  logic              accept;

  always_comb begin
    rows_eff = (frame_rows == '0) ? FR_W'(1) :
               (frame_rows > FR_W'(MAX_ROWS)) ? FR_W'(MAX_ROWS) : frame_rows;
    cols_eff = (frame_cols == '0) ? FC_W'(1) : frame_cols;
    hh       = (half_height > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_height;
    hw       = (half_width > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_width;
    wh       = {hh, 1'b1};
    nslot    = {hw, 1'b1};
    win_ok   = ({1'b0, row_pos} >= (ROW_W+1)'({hh, 1'b0})) &&
               (col_pos >= FC_W'({hw, 1'b0}));
    row_end  = (FR_W'(row_pos) + 1'b1) >= rows_eff;
    col_end  = ({1'b0, col_pos} + 1'b1) >= {1'b0, cols_eff};
    wslot_inc = (wslot + 1'b1 >= SLOT_W'(nslot)) ? '0 : wslot + 1'b1;
    // slot of the center column: wslot + hw + 1, wrapped once
    cslot_sum = (SLOT_W+1)'(wslot) + (SLOT_W+1)'(hw) + 1'b1;
    if (cslot_sum >= (SLOT_W+1)'(nslot)) begin
      cslot_sum = cslot_sum - (SLOT_W+1)'(nslot);
    end
    waddr  = ADDR_W'(wslot) * ADDR_W'(MAX_ROWS) + ADDR_W'(row_pos);
    rd_slot = (state == ST_CENTER) ? ctr_slot : rslot;
    rd_row  = (state == ST_CENTER) ? ctr_row : base_row + ROW_W'(kcnt);
    raddr  = ADDR_W'(rd_slot) * ADDR_W'(MAX_ROWS) + ADDR_W'(rd_row);
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  rfl_store u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata ({in_data.mask_bit, in_data.pixel_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Start selection once the last window word has landed
  assign sctrl.start = (state == ST_START);
  assign sctrl.rank  = rank_index;

  rfl_select u_select (
    .clk  (clk),
    .rst  (rst),
    .ctrl (sctrl),
    .pix  (win_pix),
    .sel  (win_sel),
    .stat (sstat)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows   <= FR_W'(1024);
      frame_cols   <= FC_W'(1024);
      half_height  <= HALF_W'(1);
      half_width   <= HALF_W'(1);
      element_bits <= ELEM_W'(511);
      rank_index   <= RANK_W'(4);
      mask_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ROWS:  frame_rows   <= cfg_data[FR_W-1:0];
        REG_FRAME_COLS:  frame_cols   <= cfg_data[FC_W-1:0];
        REG_HALF_HEIGHT: half_height  <= cfg_data[HALF_W-1:0];
        REG_HALF_WIDTH:  half_width   <= cfg_data[HALF_W-1:0];
        REG_ELEMENT:     element_bits <= cfg_data[ELEM_W-1:0];
        REG_RANK:        rank_index   <= cfg_data[RANK_W-1:0];
        REG_MASK_EN:     mask_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture read data into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_center <= 1'b0;
    end else begin
      rd_valid  <= (state == ST_LOAD);
      rd_center <= (state == ST_CENTER);
    end
    rd_pos <= pos;
    if (state == ST_CENTER) begin
      win_sel <= '0;
    end else if (rd_valid) begin
      win_pix[rd_pos] <= rdata.pixel;
      win_sel[rd_pos] <= element_bits[rd_pos];
    end
    if (rd_center) begin
      center <= rdata;
    end
  end

  // Scan position, sequencing and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_pos   <= '0;
      col_pos   <= '0;
      wslot     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_last <= row_end && col_end;
            base_row <= row_pos - ROW_W'({hh, 1'b0});
            ctr_row  <= row_pos - ROW_W'(hh);
            ctr_slot <= cslot_sum[SLOT_W-1:0];
            rslot    <= wslot_inc;
            ccnt     <= '0;
            kcnt     <= '0;
            pos      <= '0;
            if (win_ok) begin
              state <= ST_CENTER;
            end
            // advance the scan
            if (row_end) begin
              row_pos <= '0;
              if (col_end) begin
                col_pos <= '0;
                wslot   <= '0;
              end else begin
                col_pos <= col_pos + 1'b1;
                wslot   <= wslot_inc;
              end
            end else begin
              row_pos <= row_pos + 1'b1;
            end
          end
        end
        ST_CENTER: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          pos <= pos + 1'b1;
          if (kcnt == wh - 1'b1) begin
            kcnt  <= '0;
            ccnt  <= ccnt + 1'b1;
            rslot <= (rslot + 1'b1 >= SLOT_W'(nslot)) ? '0 : rslot + 1'b1;
            if (ccnt == SLOT_W'(nslot) - 1'b1) begin
              state <= ST_DRAIN;
            end
          end else begin
            kcnt <= kcnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (mask_enable && !center.mask) begin
            result <= center.pixel;
            state  <= ST_DONE;
          end else begin
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_SEL;
        end
        ST_SEL: begin
          if (sstat.done) begin
            result <= sstat.value;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.pixel_out  <= result;
            out_data.frame_last <= cur_last;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == ST_IDLE))
    else $error("input taken outside idle");

  a_sel_done_state: assert property (@(posedge clk) disable iff (rst)
    sstat.done |-> (state == ST_SEL))
    else $error("selection finished outside select state");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("finished word not loaded into output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !in_ready)
    else $error("input ready during window fetch");

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the masked 2D rank filter core.
module tb;
  import rfl_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  masked_2d_rank_filter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int DRAIN_CYCLES = 80;
  localparam int PLAN_ITEMS   = 1300;

  // Shadow register file and scan state
  logic [FR_W-1:0]   sh_rows = 11'd1024;
  logic [FC_W-1:0]   sh_cols = 16'd1024;
  logic [HALF_W-1:0] sh_hh = 2'd1;
  logic [HALF_W-1:0] sh_hw = 2'd1;
  logic [ELEM_W-1:0] sh_elem = 49'd511;
  logic [RANK_W-1:0] sh_rank = 6'd4;
  logic              sh_mask_en = 1'b0;
  logic [8:0]        col_store [0:SLOTS*MAX_ROWS-1];
  int unsigned       scan_row = 0;
  int unsigned       scan_col = 0;

  out_t expected_words [$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_phases = 0;
  int   send_idle = 28;
  int   recv_idle = 51;
  bit   drained_once = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned frame_height();
    if (sh_rows == 0) return 1;
    if (sh_rows > MAX_ROWS) return MAX_ROWS;
    return sh_rows;
  endfunction

  function automatic int unsigned frame_width();
    return (sh_cols == 0) ? 1 : sh_cols;
  endfunction

  // Store one pixel, rank the finished window if any, advance the scan
  function automatic void rank_window(in_t w);
    int unsigned rows, cols, hh, hw, ns, wh, row, col, c, k, cnt, rk, acc, v;
    int          hist [256];
    logic [8:0]  ctr;
    logic [8:0]  e;
    logic [7:0]  val;
    out_t        o;
    rows = frame_height();
    cols = frame_width();
    hh = sh_hh;
    hw = sh_hw;
    ns = 2 * hw + 1;
    wh = 2 * hh + 1;
    row = scan_row;
    col = scan_col;
    col_store[(col % ns) * MAX_ROWS + row] = {w.mask_bit, w.pixel_in};
    if (row >= 2 * hh && col >= 2 * hw) begin
      ctr = col_store[((col - hw) % ns) * MAX_ROWS + row - hh];
      val = '0;
      if (sh_mask_en && !ctr[8]) begin
        val = ctr[7:0];
      end else begin
        foreach (hist[i]) hist[i] = 0;
        cnt = 0;
        for (c = 0; c < ns; c++)
          for (k = 0; k < wh; k++)
            if (sh_elem[k + c * wh]) begin
              e = col_store[((col - 2 * hw + c) % ns) * MAX_ROWS + row - 2 * hh + k];
              hist[e[7:0]]++;
              cnt++;
            end
        if (cnt > 0) begin
          rk = (sh_rank >= cnt) ? cnt - 1 : sh_rank;
          acc = 0;
          for (v = 0; v < 256; v++) begin
            acc += hist[v];
            if (acc > rk) begin
              val = v[7:0];
              break;
            end
          end
        end
      end
      o.pixel_out = val;
      o.frame_last = (row + 1 >= rows) && (col + 1 >= cols);
      expected_words.push_back(o);
    end
    if (row + 1 >= rows) begin
      scan_row = 0;
      scan_col = (col + 1 >= cols) ? 0 : col + 1;
    end else begin
      scan_row = row + 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s at %0t: got %0d, want %0d", what, $realtime, got, want);
    n_errors++;
  endtask

  // Send one pixel word, idling at random first
  task automatic send_pixel(logic [7:0] pix, logic msk);
    case (n_sent * 3 / PLAN_ITEMS)
      0: begin send_idle = 28; recv_idle = 51; end
      1: begin send_idle = 51; recv_idle = 28; end
      default: begin send_idle = 0; recv_idle = 0; end
    endcase
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel_in: pix, mask_bit: msk};
    do @(posedge clk); while (!in_ready);
    rank_window('{pixel_in: pix, mask_bit: msk});
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FRAME_ROWS:  sh_rows = val[FR_W-1:0];
      REG_FRAME_COLS:  sh_cols = val[FC_W-1:0];
      REG_HALF_HEIGHT: sh_hh = val[HALF_W-1:0];
      REG_HALF_WIDTH:  sh_hw = val[HALF_W-1:0];
      REG_ELEMENT:     sh_elem = val[ELEM_W-1:0];
      REG_RANK:        sh_rank = val[RANK_W-1:0];
      REG_MASK_EN:     sh_mask_en = val[0];
      default: ;
    endcase
  endtask

  // Drain, let the core settle, then load all registers
  task automatic load_settings(int rows, int cols, int hh, int hw,
                               logic [ELEM_W-1:0] elem, int rank, bit men);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_FRAME_ROWS, CFG_W'(rows));
    write_reg(REG_FRAME_COLS, CFG_W'(cols));
    write_reg(REG_HALF_HEIGHT, CFG_W'(hh));
    write_reg(REG_HALF_WIDTH, CFG_W'(hw));
    write_reg(REG_ELEMENT, CFG_W'(elem));
    write_reg(REG_RANK, CFG_W'(rank));
    write_reg(REG_MASK_EN, CFG_W'(men));
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Whole frames of random pixels; hold off once mid-frame until drained
  task automatic send_frames(int n);
    int total;
    total = n * frame_height() * frame_width();
    for (int i = 0; i < total; i++) begin
      if (!drained_once && n_sent > 900 && i == total / 2) begin
        wait_drained();
        drained_once = 1;
      end
      send_pixel(rand_pix(), $urandom_range(3) != 0);
    end
  endtask

  task automatic test_single_pixel_frames();
    // empty element gives zero; cleared mask passes the pixel
    load_settings(0, 0, 0, 0, '0, 0, 1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd0, 1'b0);
  endtask

  task automatic test_rank_saturation();
    load_settings(3, 3, 1, 1, '1, 63, 0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'(i * 20), i[0]);
  endtask

  task automatic test_unused_element_bits();
    // only the center bit is set in range; the high bits must be ignored
    load_settings(3, 3, 1, 1, {40'hFF_FFFF_FFFF, 9'b000010000}, 0, 1);
    for (int i = 0; i < 9; i++) send_pixel(8'(255 - i), 1'b1);
  endtask

  task automatic test_tall_column();
    load_settings(1100, 1, 3, 0, ELEM_W'({$urandom, $urandom}), 48, 1);
    send_frames(1);
  endtask

  task automatic test_random_frames();
    int start;
    int done;
    logic [ELEM_W-1:0] elem;
    int rows;
    start = n_sent;
    done = 0;
    while (done < 250) begin
      elem = ($urandom_range(3) == 0) ? '1 : ELEM_W'({$urandom, $urandom});
      rows = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 12);
      load_settings(rows, $urandom_range(9), $urandom_range(3), $urandom_range(3),
                    elem, $urandom_range(63), 1'($urandom_range(1)));
      send_frames($urandom_range(1, 3));
      done = n_sent - start;
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_data.pixel_out, -1);
      end else begin
        want = expected_words.pop_front();
        if (out_data.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", out_data.pixel_out, want.pixel_out);
        if (out_data.frame_last !== want.frame_last)
          report_mismatch("frame_last", out_data.frame_last, want.frame_last);
      end
    end
  end

  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_pixel_frames();
    test_rank_saturation();
    test_unused_element_bits();
    test_tall_column();
    test_random_frames();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_words.size() != 0)
      report_mismatch("words never received", 0, expected_words.size());
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pixels over %0d register settings, %0d words checked",
             n_sent, n_phases, n_checked);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
